/* rtl/script_token_scanner_top_assert.svh */
// assertion macros for the token scanner
`ifndef SCRIPT_TOKEN_SCANNER_TOP_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define STS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Types, codes and byte classes shared by the script token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

    localparam int OFFSET_WIDTH_DEF = 32;
    localparam int LINE_WIDTH_DEF   = 24;
    localparam int MAX_RESULTS      = 3;

    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_STAR  = 8'h2A;
    localparam logic [7:0] C_SLASH = 8'h2F;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_LB    = 8'h62;
    localparam logic [7:0] C_UB    = 8'h42;
    localparam logic [7:0] C_LX    = 8'h78;
    localparam logic [7:0] C_UX    = 8'h58;
    localparam logic [7:0] C_USC   = 8'h5F;
    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_BANG  = 8'h21;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_PIPE  = 8'h7C;
    localparam logic [7:0] C_TILDE = 8'h7E;
    localparam logic [7:0] C_CARET = 8'h5E;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_LPAR  = 8'h28;
    localparam logic [7:0] C_RPAR  = 8'h29;
    localparam logic [7:0] C_LBRK  = 8'h5B;
    localparam logic [7:0] C_RBRK  = 8'h5D;
    localparam logic [7:0] C_LBRC  = 8'h7B;
    localparam logic [7:0] C_RBRC  = 8'h7D;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_SEMI  = 8'h3B;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_ONE   = 8'h31;

    typedef enum logic [5:0] {
        K_EOF, K_EOL, K_SPACE, K_COMMENT, K_ADD, K_ADD_ASSIGN, K_INC, K_SUB,
        K_SUB_ASSIGN, K_DEC, K_ARROW, K_MUL, K_MUL_ASSIGN, K_DIV, K_DIV_ASSIGN,
        K_MOD, K_MOD_ASSIGN, K_GREATER, K_GREATER_EQUAL, K_SHR, K_SHR_ASSIGN,
        K_LESS, K_LESS_EQUAL, K_SHL, K_SHL_ASSIGN, K_ASSIGN, K_EQUAL,
        K_LOGIC_NOT, K_NOT_EQUAL, K_AND, K_AND_ASSIGN, K_LOGIC_AND, K_OR,
        K_OR_ASSIGN, K_LOGIC_OR, K_NOT, K_NOT_ASSIGN, K_XOR, K_XOR_ASSIGN,
        K_DOT, K_ELLIPSIS, K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_LBRACE,
        K_RBRACE, K_COLON, K_SEMI, K_COMMA, K_STRING, K_CHAR, K_LONG,
        K_DOUBLE, K_WORD, K_UNKNOWN
    } t_kind;

    typedef enum logic [5:0] {
        M_IDLE, M_CR, M_SPACE, M_PLUS, M_MINUS, M_STAR, M_SLASH, M_PERCENT,
        M_GT, M_GTGT, M_LT, M_LTLT, M_EQ, M_BANG, M_AMP, M_PIPE, M_TILDE,
        M_CARET, M_DOT, M_DOTDOT, M_LCOM, M_LCOM_CR, M_BCOM, M_BCOM_STAR,
        M_STR, M_STR_ESC, M_CHR, M_CHR_ESC, M_ZERO, M_BIN, M_HEX, M_DEC,
        M_DECF, M_IDENT
    } t_mode;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [23:0] line;
    } t_res;

    typedef struct packed {
        t_mode mode;
        logic  emit;
        t_kind kind;
    } t_fresh;

    typedef struct packed {
        t_mode mode;
        logic  done;
        logic  rej;
        logic  inc;
        t_kind kind;
    } t_adv;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_dig(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || c == C_USC;
    endfunction

    function automatic t_kind pend_kind(input t_mode m);
        case (m)
            M_SPACE:                              return K_SPACE;
            M_PLUS:                               return K_ADD;
            M_MINUS:                              return K_SUB;
            M_STAR:                               return K_MUL;
            M_SLASH:                              return K_DIV;
            M_PERCENT:                            return K_MOD;
            M_GT:                                 return K_GREATER;
            M_GTGT:                               return K_SHR;
            M_LT:                                 return K_LESS;
            M_LTLT:                               return K_SHL;
            M_EQ:                                 return K_ASSIGN;
            M_BANG:                               return K_LOGIC_NOT;
            M_AMP:                                return K_AND;
            M_PIPE:                               return K_OR;
            M_TILDE:                              return K_NOT;
            M_CARET:                              return K_XOR;
            M_DOT:                                return K_DOT;
            M_LCOM, M_LCOM_CR, M_BCOM, M_BCOM_STAR: return K_COMMENT;
            M_STR, M_STR_ESC:                     return K_STRING;
            M_CHR, M_CHR_ESC:                     return K_CHAR;
            M_ZERO, M_BIN, M_HEX, M_DEC:          return K_LONG;
            M_DECF:                               return K_DOUBLE;
            M_IDENT:                              return K_WORD;
            default:                              return K_UNKNOWN;
        endcase
    endfunction

    function automatic t_fresh fresh_of(input logic [7:0] c);
        t_fresh f;
        f.mode = M_IDLE;
        f.emit = 1'b0;
        f.kind = K_UNKNOWN;
        case (c)
            C_CR:          f.mode = M_CR;
            C_LF:          begin f.emit = 1'b1; f.kind = K_EOL; end
            C_SP, C_TAB:   f.mode = M_SPACE;
            C_PLUS:        f.mode = M_PLUS;
            C_MINUS:       f.mode = M_MINUS;
            C_STAR:        f.mode = M_STAR;
            C_SLASH:       f.mode = M_SLASH;
            C_PCT:         f.mode = M_PERCENT;
            C_GT:          f.mode = M_GT;
            C_LT:          f.mode = M_LT;
            C_EQ:          f.mode = M_EQ;
            C_BANG:        f.mode = M_BANG;
            C_AMP:         f.mode = M_AMP;
            C_PIPE:        f.mode = M_PIPE;
            C_TILDE:       f.mode = M_TILDE;
            C_CARET:       f.mode = M_CARET;
            C_DOT:         f.mode = M_DOT;
            C_DQ:          f.mode = M_STR;
            C_SQ:          f.mode = M_CHR;
            C_LPAR:        begin f.emit = 1'b1; f.kind = K_LPAREN; end
            C_RPAR:        begin f.emit = 1'b1; f.kind = K_RPAREN; end
            C_LBRK:        begin f.emit = 1'b1; f.kind = K_LBRACK; end
            C_RBRK:        begin f.emit = 1'b1; f.kind = K_RBRACK; end
            C_LBRC:        begin f.emit = 1'b1; f.kind = K_LBRACE; end
            C_RBRC:        begin f.emit = 1'b1; f.kind = K_RBRACE; end
            C_COLON:       begin f.emit = 1'b1; f.kind = K_COLON; end
            C_SEMI:        begin f.emit = 1'b1; f.kind = K_SEMI; end
            C_COMMA:       begin f.emit = 1'b1; f.kind = K_COMMA; end
            default: begin
                if (c == C_ZERO) f.mode = M_ZERO;
                else if (is_dig(c)) f.mode = M_DEC;
                else if (is_word(c)) f.mode = M_IDENT;
                else f.emit = 1'b1;
            end
        endcase
        return f;
    endfunction

    function automatic t_adv fin(input t_mode m, input t_kind k);
        t_adv a;
        a.mode = m;
        a.done = 1'b1;
        a.rej  = 1'b0;
        a.inc  = 1'b0;
        a.kind = k;
        return a;
    endfunction

    function automatic t_adv adv_of(input t_mode m, input logic [7:0] c);
        t_adv a;
        a.mode = m;
        a.done = 1'b0;
        a.rej  = 1'b0;
        a.inc  = 1'b0;
        a.kind = K_UNKNOWN;
        case (m)
            M_CR: begin
                if (c == C_LF) begin a = fin(m, K_EOL); a.inc = 1'b1; end
                else a.rej = 1'b1;
            end
            M_SPACE:   a.rej = !(c == C_SP || c == C_TAB);
            M_PLUS: begin
                if (c == C_EQ) a = fin(m, K_ADD_ASSIGN);
                else if (c == C_PLUS) a = fin(m, K_INC);
                else a.rej = 1'b1;
            end
            M_MINUS: begin
                if (c == C_GT) a = fin(m, K_ARROW);
                else if (c == C_EQ) a = fin(m, K_SUB_ASSIGN);
                else if (c == C_MINUS) a = fin(m, K_DEC);
                else a.rej = 1'b1;
            end
            M_STAR: begin
                if (c == C_EQ) a = fin(m, K_MUL_ASSIGN); else a.rej = 1'b1;
            end
            M_SLASH: begin
                if (c == C_SLASH) a.mode = M_LCOM;
                else if (c == C_STAR) a.mode = M_BCOM;
                else if (c == C_EQ) a = fin(m, K_DIV_ASSIGN);
                else a.rej = 1'b1;
            end
            M_PERCENT: begin
                if (c == C_EQ) a = fin(m, K_MOD_ASSIGN); else a.rej = 1'b1;
            end
            M_GT: begin
                if (c == C_GT) a.mode = M_GTGT;
                else if (c == C_EQ) a = fin(m, K_GREATER_EQUAL);
                else a.rej = 1'b1;
            end
            M_GTGT: begin
                if (c == C_EQ) a = fin(m, K_SHR_ASSIGN); else a.rej = 1'b1;
            end
            M_LT: begin
                if (c == C_LT) a.mode = M_LTLT;
                else if (c == C_EQ) a = fin(m, K_LESS_EQUAL);
                else a.rej = 1'b1;
            end
            M_LTLT: begin
                if (c == C_EQ) a = fin(m, K_SHL_ASSIGN); else a.rej = 1'b1;
            end
            M_EQ: begin
                if (c == C_EQ) a = fin(m, K_EQUAL); else a.rej = 1'b1;
            end
            M_BANG: begin
                if (c == C_EQ) a = fin(m, K_NOT_EQUAL); else a.rej = 1'b1;
            end
            M_AMP: begin
                if (c == C_AMP) a = fin(m, K_LOGIC_AND);
                else if (c == C_EQ) a = fin(m, K_AND_ASSIGN);
                else a.rej = 1'b1;
            end
            M_PIPE: begin
                if (c == C_PIPE) a = fin(m, K_LOGIC_OR);
                else if (c == C_EQ) a = fin(m, K_OR_ASSIGN);
                else a.rej = 1'b1;
            end
            M_TILDE: begin
                if (c == C_EQ) a = fin(m, K_NOT_ASSIGN); else a.rej = 1'b1;
            end
            M_CARET: begin
                if (c == C_EQ) a = fin(m, K_XOR_ASSIGN); else a.rej = 1'b1;
            end
            M_DOT: begin
                if (c == C_DOT) a.mode = M_DOTDOT; else a.rej = 1'b1;
            end
            M_DOTDOT: begin
                if (c == C_DOT) a = fin(m, K_ELLIPSIS); else a.rej = 1'b1;
            end
            M_LCOM: begin
                if (c == C_LF) a.rej = 1'b1;
                else if (c == C_CR) a.mode = M_LCOM_CR;
            end
            M_BCOM: begin
                if (c == C_STAR) a.mode = M_BCOM_STAR;
                else if (c == C_LF) a.inc = 1'b1;
            end
            M_BCOM_STAR: begin
                if (c == C_SLASH) a = fin(m, K_COMMENT);
                else begin
                    a.inc = (c == C_LF);
                    if (c != C_STAR) a.mode = M_BCOM;
                end
            end
            M_STR: begin
                if (c == C_BSL) a.mode = M_STR_ESC;
                else if (c == C_DQ) a = fin(m, K_STRING);
            end
            M_STR_ESC: a.mode = M_STR;
            M_CHR: begin
                if (c == C_BSL) a.mode = M_CHR_ESC;
                else if (c == C_SQ) a = fin(m, K_CHAR);
            end
            M_CHR_ESC: a.mode = M_CHR;
            M_ZERO: begin
                if (c == C_LB || c == C_UB) a.mode = M_BIN;
                else if (c == C_LX || c == C_UX) a.mode = M_HEX;
                else if (c == C_DOT) a.mode = M_DECF;
                else begin
                    a.mode = M_DEC;
                    a.rej  = !is_dig(c);
                end
            end
            M_BIN:     a.rej = !(c == C_ZERO || c == C_ONE);
            M_HEX:     a.rej = !is_hex(c);
            M_DEC: begin
                if (c == C_DOT) a.mode = M_DECF; else a.rej = !is_dig(c);
            end
            M_DECF:    a.rej = !is_dig(c);
            M_IDENT:   a.rej = !is_word(c);
            default:   a.rej = 1'b1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* rtl/script_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// script_token_scanner_top
// Streaming lexer: one source byte per item in, up to three tokens out.
// ----------------------------------------------------------------------------
//  channel | signals                                    | dir
//  source  | i_valid o_stall i_source_byte i_end_of_source | in
//  token   | o_valid i_stall o_token_kind o_token_start    | out
//          | o_token_length o_token_line o_last_of_run     |
//
//  a byte is taken every cycle, while i_stall is low, if its results fit one per cycle
//  a byte giving more than one result holds the source side while the
//  three-entry result buffer drains, when not stalled, one token per cycle
//  synchronous reset returns to offset 0, line 0, no token pending
//  the source side is held while results, the last one included, wait
// ----------------------------------------------------------------------------
`default_nettype none

module script_token_scanner_top #(
    parameter int OFFSET_WIDTH = sts_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = sts_pkg::LINE_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_end_of_source,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [5:0]       o_token_kind,
    output logic [31:0]      o_token_start,
    output logic [31:0]      o_token_length,
    output logic [23:0]      o_token_line,
    output logic             o_last_of_run
);
    import sts_pkg::*;

    `include "script_token_scanner_top_assert.svh"

    localparam int OW  = OFFSET_WIDTH;
    localparam int LW  = LINE_WIDTH;
    localparam int CW  = (OW + 1 > 33) ? OW + 1 : 33;
    localparam int LCW = (LW > 24) ? LW : 24;
    localparam logic [OW-1:0] OFF_MAX = {OW{1'b1}};
    localparam logic [LW-1:0] LN_MAX  = {LW{1'b1}};

    t_mode          r_mode, n_mode;
    logic [OW-1:0]  r_off, n_off, r_ps, n_ps;
    logic [LW-1:0]  r_lc, n_lc, r_pl, n_pl;
    t_res           r_buf [0:2];
    t_res           n_res [0:2];
    logic [1:0]     r_cnt, n_cnt, r_idx;

    logic           acc, take, buf_last;
    logic [OW-1:0]  nxt;
    t_fresh         fr;
    t_adv           ad;
    logic           do_fresh;
    logic [OW-1:0]  crpos;

    function automatic t_res mk(input logic [5:0] k, input logic [OW-1:0] s,
                                input logic [OW:0] e, input logic [LW-1:0] l);
        logic [OW:0]    d;
        logic [CW-1:0]  sx;
        logic [CW-1:0]  dx;
        logic [LCW-1:0] lx;
        t_res           r;
        d  = (e >= {1'b0, s}) ? e - {1'b0, s} : '0;
        sx = CW'(s);
        dx = CW'(d);
        lx = LCW'(l);
        r.kind  = k;
        r.start = (sx > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sx[31:0];
        r.len   = (dx > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : dx[31:0];
        r.line  = (lx > LCW'(24'hFF_FFFF)) ? 24'hFF_FFFF : lx[23:0];
        return r;
    endfunction

    function automatic logic [LW-1:0] lsat(input logic [LW-1:0] v);
        return (v == LN_MAX) ? v : v + LW'(1);
    endfunction

    // result buffer handshake
    assign o_valid  = (r_cnt != 2'd0);
    assign buf_last = (r_idx == r_cnt - 2'd1);
    assign take     = o_valid && !i_stall;
    assign o_stall  = o_valid && !(take && buf_last);
    assign acc      = i_valid && !o_stall;

    assign o_token_kind   = r_buf[r_idx].kind;
    assign o_token_start  = r_buf[r_idx].start;
    assign o_token_length = r_buf[r_idx].len;
    assign o_token_line   = r_buf[r_idx].line;
    assign o_last_of_run  = buf_last;

    assign nxt   = (r_off == OFF_MAX) ? r_off : r_off + OW'(1);
    assign crpos = (r_off > r_ps) ? r_off - OW'(1) : r_off;
    assign fr    = fresh_of(i_source_byte);
    assign ad    = adv_of(r_mode, i_source_byte);

    always_comb begin
        n_mode   = r_mode;
        n_ps     = r_ps;
        n_pl     = r_pl;
        n_lc     = r_lc;
        n_off    = nxt;
        n_cnt    = 2'd0;
        do_fresh = 1'b0;
        for (int i = 0; i < 3; i++) n_res[i] = '0;

        if (r_mode == M_IDLE) begin
            do_fresh = 1'b1;
        end else if (r_mode == M_LCOM_CR) begin
            if (i_source_byte == C_LF) begin
                n_res[0] = mk(K_COMMENT, r_ps, {1'b0, crpos}, r_pl);
                n_res[1] = mk(K_EOL, crpos, {1'b0, r_off} + (OW+1)'(1), r_lc);
                n_cnt    = 2'd2;
                n_lc     = lsat(r_lc);
                n_mode   = M_IDLE;
            end else if (i_source_byte != C_CR) begin
                n_mode = M_LCOM;
            end
        end else begin
            if (ad.inc) n_lc = lsat(r_lc);
            if (ad.done) begin
                n_res[0] = mk(ad.kind, r_ps, {1'b0, r_off} + (OW+1)'(1), r_pl);
                n_cnt    = 2'd1;
                n_mode   = M_IDLE;
            end else if (ad.rej) begin
                n_res[0] = mk(pend_kind(ad.mode), r_ps, {1'b0, r_off}, r_pl);
                n_cnt    = 2'd1;
                do_fresh = 1'b1;
            end else begin
                n_mode = ad.mode;
            end
        end

        if (do_fresh) begin
            n_ps   = r_off;
            n_pl   = n_lc;
            n_mode = fr.mode;
            if (fr.emit) begin
                n_res[n_cnt] = mk(fr.kind, r_off, {1'b0, r_off} + (OW+1)'(1), n_lc);
                n_cnt        = n_cnt + 2'd1;
            end
            if (i_source_byte == C_LF) n_lc = lsat(n_lc);
        end

        if (i_end_of_source) begin
            if (n_mode != M_IDLE) begin
                n_res[n_cnt] = mk(pend_kind(n_mode), n_ps, {1'b0, r_off} + (OW+1)'(1),
                                  n_pl);
                n_cnt        = n_cnt + 2'd1;
            end
            n_res[n_cnt] = mk(K_EOF, nxt, {1'b0, nxt}, n_lc);
            n_cnt        = n_cnt + 2'd1;
            n_mode       = M_IDLE;
            n_off        = '0;
            n_ps         = '0;
            n_lc         = '0;
            n_pl         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_off  <= '0;
            r_ps   <= '0;
            r_lc   <= '0;
            r_pl   <= '0;
            r_cnt  <= 2'd0;
            r_idx  <= 2'd0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_off  <= n_off;
            r_ps   <= n_ps;
            r_lc   <= n_lc;
            r_pl   <= n_pl;
            r_cnt  <= n_cnt;
            r_idx  <= 2'd0;
        end else if (take) begin
            if (buf_last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int i = 0; i < 3; i++) r_buf[i] <= n_res[i];
        end
    end

    `STS_ASSERT_NOW(a_hold_mid_run, o_valid && !o_last_of_run, o_stall, "source taken mid run")
    `STS_ASSERT_NOW(a_eof_shape, o_valid && o_token_kind == K_EOF, o_token_length == 32'd0 && o_last_of_run, "bad eof token")
    `STS_ASSERT_NEXT(a_eos_clears, i_valid && !o_stall && i_end_of_source, r_off == '0 && r_mode == M_IDLE, "state kept after end of source")

endmodule

`default_nettype wire
